>>> rtl/bqts_pkg.sv
// Shared types and constants for the bracket and quote tracking scanner.
`default_nettype none

package bqts_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  // Bracket kinds held on the stack.
  typedef enum logic [1:0] {
    KIND_PAREN = 2'd0,
    KIND_BRACK = 2'd1,
    KIND_BRACE = 2'd2
  } kind_t;

  // Quote modes reported in inside_quote.
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       buffer_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic [6:0]  nest_depth;
    logic [1:0]  inside_quote;
    logic [31:0] line_number;
    logic        closer_mismatch;
    logic        stack_overflow;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/bracket_quote_tracking_scanner_core.sv
// Top level of the bracket and quote tracking scanner: one byte in, at most one byte out.
`default_nettype none

// Channel | Direction | Handshake         | Beat
// in      | input     | in_valid/in_stall | in_data (text_byte, buffer_start)
// out     | output    | out_valid/out_stall | out_data (char, depth, quote, line, flags)
//
// A byte is taken into the input register, and its result is registered in the output register
// when the byte proceeds; one byte per cycle is sustained while the output is not stalled.
// The stack top lives in a register and the entry below it is kept pre-read from the
// stack memory, so matching and popping need no wait on a memory read.
// Reset (rst, synchronous) empties the stack, clears the quote mode and the line count,
// and sets the leading whitespace suppression. A stalled output holds the input side
// only when the waiting byte would produce a result.

module bracket_quote_tracking_scanner_core #(
  parameter int STACK_DEPTH = bqts_pkg::STACK_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire bqts_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output bqts_pkg::out_beat_t      out_data
);
  import bqts_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Input register.
  logic     in_q_valid;
  in_beat_t in_q;

  // Scanner state.
  logic [CW-1:0] count, count_next;
  logic [1:0]    quote_mode, quote_mode_next;
  logic          last_was_space, last_was_space_next;
  logic [31:0]   newline_count, newline_count_next;
  kind_t         top, top_next;
  kind_t         below;

  kind_t         stack_mem [STACK_DEPTH];
  logic [AW-1:0] rd_addr;
  logic          push;

  logic          proceed;
  logic          emit;
  out_beat_t     result;

  logic [7:0]    c;
  logic [CW-1:0] cnt;
  logic          lws;
  logic          is_ws, is_nl;
  logic          is_open, is_close;
  kind_t         open_kind, close_kind;

  always_comb begin
    c   = in_q.text_byte;
    cnt = in_q.buffer_start ? '0 : count;
    lws = in_q.buffer_start ? 1'b1 : last_was_space;

    is_nl = (c == CH_LF) || (c == CH_CR);
    is_ws = is_nl || (c == CH_SPACE) || (c == CH_TAB);

    is_open   = 1'b1;
    open_kind = KIND_PAREN;
    case (c)
      CH_LPAREN: open_kind = KIND_PAREN;
      CH_LBRACK: open_kind = KIND_BRACK;
      CH_LBRACE: open_kind = KIND_BRACE;
      default:   is_open = 1'b0;
    endcase

    is_close   = 1'b1;
    close_kind = KIND_PAREN;
    case (c)
      CH_RPAREN: close_kind = KIND_PAREN;
      CH_RBRACK: close_kind = KIND_BRACK;
      CH_RBRACE: close_kind = KIND_BRACE;
      default:   is_close = 1'b0;
    endcase

    count_next          = cnt;
    quote_mode_next     = quote_mode;
    last_was_space_next = lws;
    newline_count_next  = newline_count;
    top_next            = top;
    push                = 1'b0;
    emit                = 1'b1;
    result              = '0;
    result.out_char     = c;

    if (is_nl && (newline_count != 32'hFFFF_FFFF)) begin
      newline_count_next = newline_count + 32'd1;
    end

    if (is_ws) begin
      emit                = !lws;
      last_was_space_next = 1'b1;
      result.out_char     = CH_SPACE;
    end else begin
      last_was_space_next = 1'b0;
      if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        if (quote_mode == QUOTE_NONE) begin
          quote_mode_next = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
        end else if ((quote_mode == QUOTE_SINGLE && c == CH_SQUOTE) ||
                     (quote_mode == QUOTE_DOUBLE && c == CH_DQUOTE)) begin
          quote_mode_next = QUOTE_NONE;
        end
      end else if (quote_mode == QUOTE_NONE) begin
        if (is_open) begin
          if (cnt < CW'(STACK_DEPTH)) begin
            push       = 1'b1;
            top_next   = open_kind;
            count_next = cnt + CW'(1);
          end else begin
            result.stack_overflow = 1'b1;
          end
        end else if (is_close) begin
          if ((cnt != '0) && (top == close_kind)) begin
            // The pre-read entry below the top becomes the new top.
            top_next   = below;
            count_next = cnt - CW'(1);
          end else begin
            result.closer_mismatch = 1'b1;
          end
        end
      end
    end

    result.nest_depth   = 7'(count_next);
    result.inside_quote = quote_mode_next;
    result.line_number  = newline_count_next;
  end

  assign proceed  = in_q_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !proceed;

  // Address of the entry just below the top after this cycle's update.
  always_comb begin
    if (proceed) begin
      rd_addr = (count_next < CW'(2)) ? '0 : AW'(count_next - CW'(2));
    end else begin
      rd_addr = (count < CW'(2)) ? '0 : AW'(count - CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && push) begin
      stack_mem[AW'(cnt)] <= top_next;
    end
    below <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid     <= 1'b0;
      out_valid      <= 1'b0;
      count          <= '0;
      quote_mode     <= QUOTE_NONE;
      last_was_space <= 1'b1;
      newline_count  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (proceed) begin
        in_q_valid <= 1'b0;
      end

      if (proceed) begin
        count          <= count_next;
        quote_mode     <= quote_mode_next;
        last_was_space <= last_was_space_next;
        newline_count  <= newline_count_next;
      end

      if (proceed && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (proceed) begin
      top <= top_next;
    end
    if (proceed && emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
